// File: src/thacc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating arithmetic for the threshold histogram accumulator.
package thacc_pkg;

  localparam int NUM_BINS = 7;
  localparam int BIN_W    = 3;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LAST  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 3'd7;

  localparam logic signed [VAL_W-1:0] LOWER_BOUND_RESET = 32'sd0;
  localparam logic [BIN_W-1:0]        BINS_IN_USE_RESET = 3'd7;

  localparam logic signed [VAL_W-1:0] BOUND_RESET [1:6] = '{
    32'sd589824, 32'sd1114112, 32'sd2228224, 32'sd3276800, 32'sd4390912, 32'sd6553600
  };

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] bin_value;
    logic signed [VAL_W-1:0] measurement;
    logic [BIN_W-1:0]        bin_select;
  } req_t;

  typedef struct packed {
    logic [BIN_W-1:0]        hit_bin;
    logic                    dropped;
    logic [CNT_W-1:0]        bin_count;
    logic signed [SUM_W-1:0] bin_sum;
    logic [CNT_W-1:0]        total_count;
    logic signed [SUM_W-1:0] total_sum;
  } rsp_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic                    dropped;
    logic [BIN_W-1:0]        hit_bin;
    logic signed [VAL_W-1:0] measurement;
  } cmd_t;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic signed [SUM_W-1:0] add_sat(input logic signed [SUM_W-1:0] s,
                                                     input logic signed [VAL_W-1:0] m);
    logic signed [SUM_W:0] r;
    r = {s[SUM_W-1], s} + {{(SUM_W+1-VAL_W){m[VAL_W-1]}}, m};
    if (r[SUM_W] != r[SUM_W-1]) begin
      return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r[SUM_W-1:0];
  endfunction

endpackage

// File: src/thacc_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, request accept and bin classification.
module thacc_front import thacc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  input  logic                  full,
  output logic                  push,
  output cmd_t                  cmd
);

  logic signed [VAL_W-1:0] lower_bound;
  logic signed [VAL_W-1:0] bounds [1:6];
  logic [BIN_W-1:0]        bins_in_use;
  logic [BIN_W-1:0]        used;
  logic [BIN_W-1:0]        bin;
  logic                    below;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= LOWER_BOUND_RESET;
      bounds      <= BOUND_RESET;
      bins_in_use <= BINS_IN_USE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LOWER_BOUND) begin
        lower_bound <= cfg_data;
      end else if (cfg_index inside {[CFG_BOUND_FIRST:CFG_BOUND_LAST]}) begin
        bounds[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_BINS_IN_USE) begin
        bins_in_use <= cfg_data[BIN_W-1:0];
      end
    end
  end

  always_comb begin
    used  = (bins_in_use == '0) ? BIN_W'(1) : bins_in_use;
    below = req.bin_value < lower_bound;
    bin   = used - 1'b1;
    for (int i = NUM_BINS - 2; i >= 0; i--) begin
      if ((BIN_W'(i + 1) < used) && (bounds[i + 1] > req.bin_value)) begin
        bin = BIN_W'(i);
      end
    end
  end

  always_comb begin
    cmd.opcode      = req.opcode;
    cmd.measurement = req.measurement;
    cmd.dropped     = 1'b0;
    cmd.hit_bin     = '0;
    case (req.opcode)
      OP_ADD: begin
        cmd.dropped = below;
        cmd.hit_bin = below ? '0 : bin;
      end
      OP_READ: begin
        cmd.hit_bin = req.bin_select;
      end
      default: begin
        cmd.hit_bin = '0;
      end
    endcase
  end

  assign req_stall = full;
  assign push      = req_valid && !full;

endmodule

// File: src/thacc_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the store.
module thacc_queue import thacc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic pop,
  input  cmd_t wr_cmd,
  output logic full,
  output logic empty,
  output cmd_t rd_cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  assign full   = count == 2'd2;
  assign empty  = count == 2'd0;
  assign rd_cmd = entries[rd_ptr];

endmodule

// File: src/thacc_back.sv
`timescale 1ns / 1ps
// Back end: bin and total stores, saturating update and result register.
module thacc_back import thacc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  cmd_t cmd,
  output logic pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic [CNT_W-1:0]        counts [NUM_BINS];
  logic signed [SUM_W-1:0] sums   [NUM_BINS];
  logic [CNT_W-1:0]        all_count;
  logic signed [SUM_W-1:0] all_sum;

  logic                    in_range;
  logic [CNT_W-1:0]        cur_cnt;
  logic signed [SUM_W-1:0] cur_sum;
  logic [CNT_W-1:0]        cnt_next;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        all_count_next;
  logic signed [SUM_W-1:0] all_sum_next;
  logic                    do_add;
  rsp_t                    rsp_next;

  assign pop = !empty && (!rsp_valid || !rsp_stall);

  always_comb begin
    in_range       = cmd.hit_bin < BIN_W'(NUM_BINS);
    cur_cnt        = in_range ? counts[cmd.hit_bin] : '0;
    cur_sum        = in_range ? sums[cmd.hit_bin] : '0;
    cnt_next       = inc_sat(cur_cnt);
    sum_next       = add_sat(cur_sum, cmd.measurement);
    all_count_next = inc_sat(all_count);
    all_sum_next   = add_sat(all_sum, cmd.measurement);
    do_add         = (cmd.opcode == OP_ADD) && !cmd.dropped;

    rsp_next             = '0;
    rsp_next.total_count = all_count;
    rsp_next.total_sum   = all_sum;
    case (cmd.opcode)
      OP_ADD: begin
        rsp_next.dropped = cmd.dropped;
        if (!cmd.dropped) begin
          rsp_next.hit_bin     = cmd.hit_bin;
          rsp_next.bin_count   = cnt_next;
          rsp_next.bin_sum     = sum_next;
          rsp_next.total_count = all_count_next;
          rsp_next.total_sum   = all_sum_next;
        end
      end
      OP_CLEAR: begin
        rsp_next.total_count = '0;
        rsp_next.total_sum   = '0;
      end
      OP_READ: begin
        rsp_next.hit_bin   = cmd.hit_bin;
        rsp_next.bin_count = cur_cnt;
        rsp_next.bin_sum   = cur_sum;
      end
      default: begin
        rsp_next.hit_bin = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        counts[i] <= '0;
        sums[i]   <= '0;
      end
      all_count <= '0;
      all_sum   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (do_add) begin
          counts[cmd.hit_bin] <= cnt_next;
          sums[cmd.hit_bin]   <= sum_next;
          all_count           <= all_count_next;
          all_sum             <= all_sum_next;
        end else if (cmd.opcode == OP_CLEAR) begin
          for (int i = 0; i < NUM_BINS; i++) begin
            counts[i] <= '0;
            sums[i]   <= '0;
          end
          all_count <= '0;
          all_sum   <= '0;
        end
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: src/threshold_histogram_accumulator.sv
`timescale 1ns / 1ps
// Threshold histogram accumulator top level.
// Each accepted beat is queued; the back end pops it and registers the result beat.
// Throughput: one beat per cycle unless the result stalls; the bin store update sets it.
// A two-entry command queue lets the front end take beats while the result is stalled.
// Reset clears all counts and sums and loads the bound registers' defaults.
module threshold_histogram_accumulator import thacc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t front_cmd;
  cmd_t back_cmd;

  thacc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .full      (q_full),
    .push      (q_push),
    .cmd       (front_cmd)
  );

  thacc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .pop    (q_pop),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .empty  (q_empty),
    .rd_cmd (back_cmd)
  );

  thacc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .cmd       (back_cmd),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: src/thacc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the threshold histogram accumulator, bound to the top level.
module thacc_checker import thacc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid)
    else $error("request beat dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.dropped |-> rsp.hit_bin == '0 && rsp.bin_count == '0 && rsp.bin_sum == '0)
    else $error("dropped beat carries bin totals");

  a_bin_le_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit_bin < BIN_W'(NUM_BINS) |-> rsp.bin_count <= rsp.total_count)
    else $error("bin count exceeds total count");

endmodule

bind threshold_histogram_accumulator thacc_checker u_thacc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
